// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed: next-cycle implication");

`endif

// ===== rtl/cfa_pkg.sv =====
// Shared types, codes and constants of the contiguous frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

    localparam int OP_W       = 2;
    localparam int FRAME_W    = 20;
    localparam int CNT_W      = 11;
    localparam int STAT_W     = 3;
    localparam int MAP_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // One info frame covers this many pool frames.
    localparam int FRAMES_PER_INFO_FRAME = 16384;

    localparam logic [CNT_W-1:0] RESET_FREE = 11'd1024;
    localparam logic [CNT_W-1:0] RESET_POOL = 11'd1024;

    // Operations
    localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd3;

    // Result status
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_FEW   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_RUN    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_HEAD  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_OUT_RANGE = 3'd4;

    // Frame map entry states
    localparam logic [MAP_W-1:0] MAP_FREE = 2'd0;
    localparam logic [MAP_W-1:0] MAP_USED = 2'd1;
    localparam logic [MAP_W-1:0] MAP_HEAD = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FRAMES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_INFO = 2'd2;

    // Pointer source
    localparam logic [2:0] PTR_HOLD  = 3'd0;
    localparam logic [2:0] PTR_ZERO  = 3'd1;
    localparam logic [2:0] PTR_INC   = 3'd2;
    localparam logic [2:0] PTR_START = 3'd3;
    localparam logic [2:0] PTR_REL   = 3'd4;

    // Run start source (zero also clears the run length)
    localparam logic [1:0] START_HOLD = 2'd0;
    localparam logic [1:0] START_ZERO = 2'd1;
    localparam logic [1:0] START_REL  = 2'd2;

    // Map write value
    localparam logic [1:0] WR_FREE = 2'd0;
    localparam logic [1:0] WR_RUN  = 2'd1;
    localparam logic [1:0] WR_INIT = 2'd2;

    // Free count update
    localparam logic [2:0] FC_HOLD = 3'd0;
    localparam logic [2:0] FC_INIT = 3'd1;
    localparam logic [2:0] FC_INC  = 3'd2;
    localparam logic [2:0] FC_MARK = 3'd3;
    localparam logic [2:0] FC_SUB  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [FRAME_W-1:0] frame_num;
        logic [CNT_W-1:0]   count;
    } t_cmd_word;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] first_frame;
        logic [CNT_W-1:0]   free_frames;
    } t_result_word;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic [2:0]        ptr_sel;
        logic [1:0]        start_sel;
        logic              scan_step;
        logic              wr_en;
        logic [1:0]        wr_sel;
        logic [2:0]        fc_sel;
        logic              left_load;
        logic              left_dec;
        logic              status_set;
        logic [STAT_W-1:0] status;
        logic              first_set;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_gt_free;
        logic            cnt_zero;
        logic            pool_empty;
        logic            rel_bad;
        logic            mark_over;
        logic            rd_used;
        logic            rd_head;
        logic            run_hit;
        logic            ptr_last;
        logic            ptr_in_pool;
        logic            left_last;
        logic            sweep_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/cfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/cfa_ctrl.sv =====
// Allocator controller: operation sequencing state machine.
`timescale 1ns / 1ps
`default_nettype none

module cfa_ctrl import cfa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy,
    output logic         o_done
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_INIT   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_AWR    = 4'd5;
    localparam logic [3:0] S_RHEAD  = 4'd6;
    localparam logic [3:0] S_RWALK  = 4'd7;
    localparam logic [3:0] S_MARK   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_FREE;
                o_cmd.ptr_sel = PTR_INC;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_INIT: begin
                        o_cmd.ptr_sel = PTR_ZERO;
                        o_cmd.fc_sel  = FC_INIT;
                        n_state       = S_INIT;
                    end
                    OP_ALLOC: begin
                        if (i_sts.cnt_gt_free) begin
                            o_cmd.status_set = 1'b1;
                            o_cmd.status     = STAT_TOO_FEW;
                            n_state          = S_DONE;
                        end else if (i_sts.cnt_zero || i_sts.pool_empty) begin
                            o_cmd.status_set = 1'b1;
                            o_cmd.status     = STAT_NO_RUN;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.ptr_sel   = PTR_ZERO;
                            o_cmd.start_sel = START_ZERO;
                            n_state         = S_SCAN;
                        end
                    end
                    OP_RELEASE: begin
                        if (i_sts.rel_bad) begin
                            o_cmd.status_set = 1'b1;
                            o_cmd.status     = STAT_OUT_RANGE;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.ptr_sel = PTR_REL;
                            n_state       = S_RHEAD;
                        end
                    end
                    OP_MARK: begin
                        if (i_sts.cnt_zero || i_sts.rel_bad || i_sts.mark_over) begin
                            o_cmd.status_set = 1'b1;
                            o_cmd.status     = STAT_OUT_RANGE;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.ptr_sel   = PTR_REL;
                            o_cmd.start_sel = START_REL;
                            o_cmd.left_load = 1'b1;
                            n_state         = S_MARK;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INIT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_INIT;
                o_cmd.ptr_sel = PTR_INC;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_sts.run_hit) begin
                    o_cmd.ptr_sel   = PTR_START;
                    o_cmd.left_load = 1'b1;
                    n_state         = S_AWR;
                end else if (i_sts.ptr_last) begin
                    o_cmd.status_set = 1'b1;
                    o_cmd.status     = STAT_NO_RUN;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.ptr_sel   = PTR_INC;
                end
            end
            S_AWR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = WR_RUN;
                o_cmd.ptr_sel  = PTR_INC;
                o_cmd.left_dec = 1'b1;
                if (i_sts.left_last) begin
                    o_cmd.fc_sel    = FC_SUB;
                    o_cmd.first_set = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_RHEAD: begin
                if (!i_sts.rd_head) begin
                    o_cmd.status_set = 1'b1;
                    o_cmd.status     = STAT_NOT_HEAD;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WR_FREE;
                    o_cmd.fc_sel  = FC_INC;
                    o_cmd.ptr_sel = PTR_INC;
                    n_state       = S_RWALK;
                end
            end
            S_RWALK: begin
                if (i_sts.ptr_in_pool && i_sts.rd_used) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WR_FREE;
                    o_cmd.fc_sel  = FC_INC;
                    o_cmd.ptr_sel = PTR_INC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = WR_RUN;
                o_cmd.fc_sel   = FC_MARK;
                o_cmd.ptr_sel  = PTR_INC;
                o_cmd.left_dec = 1'b1;
                if (i_sts.left_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/cfa_dpath.sv =====
// Allocator datapath: config registers, pointers, free count, map access.
`timescale 1ns / 1ps
`default_nettype none

module cfa_dpath import cfa_pkg::*; #(
    parameter int MAX_FRAMES = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire t_cmd_word                    i_word,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_sts                           o_sts,
    output t_result_word                      o_result,
    output logic                              o_map_we,
    output logic [$clog2(MAX_FRAMES)-1:0]     o_map_waddr,
    output logic [MAP_W-1:0]                  o_map_wdata,
    output logic [$clog2(MAX_FRAMES)-1:0]     o_map_raddr,
    input  wire logic [MAP_W-1:0]             i_map_rdata
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int NW = $clog2(MAX_FRAMES + 1);

    // configuration
    logic [FRAME_W-1:0] r_base;
    logic [CNT_W-1:0]   r_pool;
    logic               r_resv;

    // operation
    logic [OP_W-1:0]    r_op;
    logic [CNT_W-1:0]   r_cnt;
    logic [FRAME_W-1:0] r_rel;
    logic               r_borrow;

    // walk state
    logic [NW-1:0]      r_ptr;
    logic [NW-1:0]      n_ptr;
    logic [NW-1:0]      r_start;
    logic [CNT_W-1:0]   r_run;
    logic [CNT_W-1:0]   r_left;
    logic [CNT_W-1:0]   r_fc;
    logic [CNT_W-1:0]   n_fc;
    logic [STAT_W-1:0]  r_status;
    logic [FRAME_W-1:0] r_first;

    logic [NW-1:0]      w_pool_n;
    logic [NW-1:0]      w_ptr_inc;
    logic [1:0]         w_info_k;
    logic               w_resv;
    logic               w_rd_free;
    logic [CNT_W-1:0]   w_fc_init;

    // effective pool size, clamped to the map depth
    assign w_pool_n  = (32'(r_pool) > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(r_pool);
    assign w_ptr_inc = r_ptr + NW'(1);
    assign w_resv    = r_resv && (w_pool_n != '0);
    // pool size fits 11 bits, below one info frame: always one info frame
    assign w_info_k  = (32'(w_pool_n) > FRAMES_PER_INFO_FRAME) ? 2'd2 : 2'd1;
    assign w_fc_init = CNT_W'(w_pool_n) - (w_resv ? CNT_W'(w_info_k) : '0);
    assign w_rd_free = (i_map_rdata == MAP_FREE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_pool <= RESET_POOL;
            r_resv <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_FRAME:   r_base <= i_cfg_data;
                CFG_POOL_FRAMES:  r_pool <= i_cfg_data[CNT_W-1:0];
                CFG_RESERVE_INFO: r_resv <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.ptr_sel)
            PTR_ZERO:  n_ptr = '0;
            PTR_INC:   n_ptr = w_ptr_inc;
            PTR_START: n_ptr = r_start;
            PTR_REL:   n_ptr = NW'(r_rel);
            default:   n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.fc_sel)
            FC_INIT: n_fc = w_fc_init;
            FC_INC:  n_fc = r_fc + CNT_W'(1);
            FC_MARK: n_fc = (w_rd_free && (r_fc != '0)) ? r_fc - CNT_W'(1) : r_fc;
            FC_SUB:  n_fc = r_fc - r_cnt;
            default: n_fc = r_fc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_fc  <= RESET_FREE;
        end else begin
            r_ptr <= n_ptr;
            r_fc  <= n_fc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op                <= i_word.operation;
            r_cnt               <= i_word.count;
            {r_borrow, r_rel}   <= {1'b0, i_word.frame_num} - {1'b0, r_base};
            r_status            <= STAT_OK;
            r_first             <= '0;
        end else begin
            if (i_cmd.status_set) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.first_set) begin
                r_first <= r_base + FRAME_W'(r_start);
            end
        end

        case (i_cmd.start_sel)
            START_ZERO: begin
                r_start <= '0;
                r_run   <= '0;
            end
            START_REL: begin
                r_start <= NW'(r_rel);
            end
            default: begin
                if (i_cmd.scan_step) begin
                    if (w_rd_free) begin
                        r_run <= r_run + CNT_W'(1);
                    end else begin
                        r_run   <= '0;
                        r_start <= w_ptr_inc;
                    end
                end
            end
        endcase

        if (i_cmd.left_load) begin
            r_left <= r_cnt;
        end else if (i_cmd.left_dec) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    // map write value
    always_comb begin
        case (i_cmd.wr_sel)
            WR_RUN:  o_map_wdata = (r_ptr == r_start) ? MAP_HEAD : MAP_USED;
            WR_INIT: begin
                if (w_resv && (r_ptr == '0)) begin
                    o_map_wdata = MAP_HEAD;
                end else if (w_resv && (r_ptr < NW'(w_info_k))) begin
                    o_map_wdata = MAP_USED;
                end else begin
                    o_map_wdata = MAP_FREE;
                end
            end
            default: o_map_wdata = MAP_FREE;
        endcase
    end

    assign o_map_we    = i_cmd.wr_en;
    assign o_map_waddr = r_ptr[AW-1:0];
    // the registered read data thus belongs to the pointer then in r_ptr
    assign o_map_raddr = n_ptr[AW-1:0];

    assign o_sts.op          = r_op;
    assign o_sts.cnt_gt_free = (r_cnt > r_fc);
    assign o_sts.cnt_zero    = (r_cnt == '0);
    assign o_sts.pool_empty  = (w_pool_n == '0);
    assign o_sts.rel_bad     = r_borrow || (r_rel >= FRAME_W'(w_pool_n));
    assign o_sts.mark_over   = ((FRAME_W+1)'(r_cnt) + (FRAME_W+1)'(r_rel))
                               > (FRAME_W+1)'(w_pool_n);
    assign o_sts.rd_used     = (i_map_rdata == MAP_USED);
    assign o_sts.rd_head     = (i_map_rdata == MAP_HEAD);
    assign o_sts.run_hit     = w_rd_free && ((r_run + CNT_W'(1)) == r_cnt);
    assign o_sts.ptr_last    = (w_ptr_inc == w_pool_n);
    assign o_sts.ptr_in_pool = (r_ptr < w_pool_n);
    assign o_sts.left_last   = (r_left == CNT_W'(1));
    assign o_sts.sweep_last  = (r_ptr == NW'(MAX_FRAMES - 1));

    assign o_result.status      = r_status;
    assign o_result.first_frame = r_first;
    assign o_result.free_frames = r_fc;

endmodule

`default_nettype wire

// ===== rtl/contiguous_frame_allocator.sv =====
// Top level of the contiguous frame allocator: controller, datapath, frame map.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   | Direction | Handshake                        | Word
// ----------+-----------+----------------------------------+----------------------------------
// command   | in        | start high, busy low             | i_cmd (operation/frame_num/count)
// result    | out       | o_result_valid, one cycle        | o_result (status/first/free)
// config    | in        | i_cfg_valid and o_cfg_ready      | i_cfg_index, i_cfg_data
//
// After reset the map is swept to free with busy high; config writes are taken during
// the sweep. Per word: decode state, map walk, result state; the walk moves one frame
// per cycle (one read and one write port): init MAX_FRAMES, allocate up to pool size
// (scan) plus count (write), release up to pool size + 1, mark count. The next word is
// taken in the idle state after the result. The result shows one cycle; no receiver stall.

module contiguous_frame_allocator import cfa_pkg::*; #(
    parameter int MAX_FRAMES = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_cmd_word             i_cmd,
    output logic                       o_result_valid,
    output t_result_word               o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_FRAMES);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic             w_map_we;
    logic [AW-1:0]    w_map_waddr;
    logic [MAP_W-1:0] w_map_wdata;
    logic [AW-1:0]    w_map_raddr;
    logic [MAP_W-1:0] w_map_rdata;

    // Config registers are plain flops: a write always lands at once.
    assign o_cfg_ready = 1'b1;

    // Sequencing: one state per walk kind, the datapath does the counting.
    cfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_result_valid)
    );

    // Pointers, run tracking, free count and result registers.
    cfa_dpath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_word      (i_cmd),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_result    (o_result),
        .o_map_we    (w_map_we),
        .o_map_waddr (w_map_waddr),
        .o_map_wdata (w_map_wdata),
        .o_map_raddr (w_map_raddr),
        .i_map_rdata (w_map_rdata)
    );

    // Frame map: 2-bit state per frame (free, used, head).
    cfa_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAX_FRAMES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

    // A result strobe lasts one cycle, since done always returns to idle.
    `CFA_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    // An accepted word keeps the block busy on the next cycle.
    `CFA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // The map is only written while an operation or the reset sweep runs.
    `CFA_ASSERT_IMP(a_write_busy, i_clk, i_rst_n, w_cmd.wr_en, busy)
    // Only a successful allocate reports a first frame.
    `CFA_ASSERT_IMP(a_first_ok, i_clk, i_rst_n, o_result_valid && (o_result.status != STAT_OK),
                    o_result.first_frame == '0)

endmodule

`default_nettype wire
